[sv/md5_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 engine package
// Shared types, constants and round tables for the MD5 hash engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W = 32;

    // Initial chaining value words A, B, C, D.
    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    // Padding marker byte and the block position where the length field starts.
    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_START_POS = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;

    // Operands of the shared adder: op_a + rotl(op_b, rot).
    typedef struct packed {
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
        logic [4:0]        rot;
    } alu_req_t;

    // Additive constant of each round.
    function automatic logic [WORD_W-1:0] round_const(input logic [5:0] rnd);
        logic [WORD_W-1:0] k;
        unique case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    // Left rotation amount, chosen by stage and by the round within a group of four.
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        unique case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
        endcase
        return s;
    endfunction

    // Index of the message word that a round consumes.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] g;
        r = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: g = r;
            2'd1: g = 4'({r, 2'b00} + r + 4'd1);
            2'd2: g = 4'({r, 1'b0} + r + 4'd5);
            2'd3: g = 4'({r, 3'b000} - r);
        endcase
        return g;
    endfunction

    // Nonlinear function of each stage.
    function automatic logic [WORD_W-1:0] round_f(
        input logic [1:0]        stage,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] f;
        unique case (stage)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

[sv/md5_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 input channel
// Valid/ready channel that carries one message byte item.
// ----------------------------------------------------------------------------
interface md5_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (
        output valid,
        output data_byte,
        output byte_valid,
        output end_of_message,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  byte_valid,
        input  end_of_message,
        output ready
    );

endinterface

[sv/md5_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 output channel
// Valid/ready channel that carries one digest word item.
// ----------------------------------------------------------------------------
interface md5_out_if;

    logic                        valid;
    logic                        ready;
    logic [md5_pkg::WORD_W-1:0]  digest_word;
    logic [1:0]                  word_index;
    logic                        last_word;

    modport source (
        output valid,
        output digest_word,
        output word_index,
        output last_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  digest_word,
        input  word_index,
        input  last_word,
        output ready
    );

endinterface

[sv/md5_hash_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 hash engine
// A byte item that completes a block starts a block compression: 64 rounds
// on the shared adder, then an update of the four chaining value words.
// An end item adds padding, one or two compressions, then four digest
// word items. Reset loads the initial vector and clears counts.
// ----------------------------------------------------------------------------
module md5_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    md5_in_if.sink      in_ch,
    md5_out_if.source   out_ch
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_RND  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                        state_reg;
    logic [md5_pkg::WORD_W-1:0]    cv_reg [4];
    logic [md5_pkg::WORD_W-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic [md5_pkg::WORD_W-1:0]    acc_reg;
    logic [md5_pkg::WORD_W-1:0]    w_reg;
    logic [5:0]                    rnd_reg;
    logic [1:0]                    phase_reg;
    logic [1:0]                    idx_reg;
    logic [5:0]                    fill_reg;
    logic [60:0]                   bytes_reg;
    logic                          mark_done_reg;
    logic                          len_active_reg;
    logic                          finish_reg;
    logic                          eom_reg;

    logic [md5_pkg::WORD_W-1:0]    blk_mem [16];

    logic                          in_fire;
    logic                          out_fire;
    logic                          mem_we;
    logic [7:0]                    mem_wbyte;
    logic [63:0]                   len_bits;
    logic                          len_byte;
    logic [7:0]                    pad_byte;
    logic [md5_pkg::WORD_W-1:0]    work_sel;
    md5_pkg::alu_req_t             alu_req;
    logic [md5_pkg::WORD_W-1:0]    alu_sum;

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign out_fire = out_ch.valid & out_ch.ready;

    // Handshake and digest word output.
    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.digest_word = cv_reg[idx_reg];
    assign out_ch.word_index  = idx_reg;
    assign out_ch.last_word   = (idx_reg == 2'd3);

    // Padding byte: marker first, then zeros, then the little-endian bit length.
    always_comb
    begin
        len_bits = {bytes_reg, 3'b000};
        len_byte = mark_done_reg & (len_active_reg | (fill_reg == md5_pkg::LEN_START_POS));
        if (!mark_done_reg)
        begin
            pad_byte = md5_pkg::PAD_MARK;
        end
        else if (len_byte)
        begin
            pad_byte = len_bits[{fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Block store write port.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wbyte = in_ch.data_byte;
        if (state_reg == S_IDLE)
        begin
            mem_we = in_fire & in_ch.byte_valid;
        end
        else if (state_reg == S_PAD)
        begin
            mem_we    = 1'b1;
            mem_wbyte = pad_byte;
        end
    end

    // Block store: byte writes, one registered word read for the round in progress.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            blk_mem[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= mem_wbyte;
        end
        w_reg <= blk_mem[md5_pkg::msg_index(rnd_reg)];
    end

    // Working word that the chaining value update adds in.
    always_comb
    begin
        unique case (idx_reg)
            2'd0: work_sel = a_reg;
            2'd1: work_sel = b_reg;
            2'd2: work_sel = c_reg;
            2'd3: work_sel = d_reg;
        endcase
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req.op_a = cv_reg[idx_reg];
        alu_req.op_b = work_sel;
        alu_req.rot  = 5'd0;
        if (state_reg == S_RND)
        begin
            unique case (phase_reg)
                2'd0:
                begin
                    alu_req.op_a = a_reg;
                    alu_req.op_b = md5_pkg::round_const(rnd_reg);
                end
                2'd1:
                begin
                    alu_req.op_a = acc_reg;
                    alu_req.op_b = w_reg;
                end
                2'd2:
                begin
                    alu_req.op_a = acc_reg;
                    alu_req.op_b = md5_pkg::round_f(rnd_reg[5:4], b_reg, c_reg, d_reg);
                end
                2'd3:
                begin
                    alu_req.op_a = b_reg;
                    alu_req.op_b = acc_reg;
                    alu_req.rot  = md5_pkg::rot_amount(rnd_reg);
                end
            endcase
        end
    end

    md5_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // Sequencer: absorb bytes, pad, run rounds, update and emit the digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cv_reg[0]      <= md5_pkg::IV_A;
            cv_reg[1]      <= md5_pkg::IV_B;
            cv_reg[2]      <= md5_pkg::IV_C;
            cv_reg[3]      <= md5_pkg::IV_D;
            rnd_reg        <= '0;
            phase_reg      <= '0;
            idx_reg        <= '0;
            fill_reg       <= '0;
            bytes_reg      <= '0;
            mark_done_reg  <= 1'b0;
            len_active_reg <= 1'b0;
            finish_reg     <= 1'b0;
            eom_reg        <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        eom_reg <= in_ch.end_of_message;
                        if (in_ch.byte_valid)
                        begin
                            fill_reg  <= fill_reg + 6'd1;
                            bytes_reg <= bytes_reg + 61'd1;
                        end
                        if (in_ch.byte_valid && (fill_reg == md5_pkg::LAST_POS))
                        begin
                            state_reg <= S_RND;
                            rnd_reg   <= '0;
                            phase_reg <= '0;
                            a_reg     <= cv_reg[0];
                            b_reg     <= cv_reg[1];
                            c_reg     <= cv_reg[2];
                            d_reg     <= cv_reg[3];
                        end
                        else if (in_ch.end_of_message)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    fill_reg      <= fill_reg + 6'd1;
                    mark_done_reg <= 1'b1;
                    if (len_byte)
                    begin
                        len_active_reg <= 1'b1;
                    end
                    if (fill_reg == md5_pkg::LAST_POS)
                    begin
                        finish_reg <= len_byte;
                        state_reg  <= S_RND;
                        rnd_reg    <= '0;
                        phase_reg  <= '0;
                        a_reg      <= cv_reg[0];
                        b_reg      <= cv_reg[1];
                        c_reg      <= cv_reg[2];
                        d_reg      <= cv_reg[3];
                    end
                end
                S_RND:
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        a_reg   <= d_reg;
                        d_reg   <= c_reg;
                        c_reg   <= b_reg;
                        b_reg   <= alu_sum;
                        rnd_reg <= rnd_reg + 6'd1;
                        if (rnd_reg == md5_pkg::LAST_ROUND)
                        begin
                            state_reg <= S_FIN;
                            idx_reg   <= '0;
                        end
                    end
                    else
                    begin
                        acc_reg <= alu_sum;
                    end
                end
                S_FIN:
                begin
                    cv_reg[idx_reg] <= alu_sum;
                    idx_reg         <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        if (finish_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (eom_reg)
                        begin
                            state_reg <= S_PAD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            // Re-initialize for the next message.
                            state_reg      <= S_IDLE;
                            cv_reg[0]      <= md5_pkg::IV_A;
                            cv_reg[1]      <= md5_pkg::IV_B;
                            cv_reg[2]      <= md5_pkg::IV_C;
                            cv_reg[3]      <= md5_pkg::IV_D;
                            bytes_reg      <= '0;
                            mark_done_reg  <= 1'b0;
                            len_active_reg <= 1'b0;
                            finish_reg     <= 1'b0;
                            eom_reg        <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/md5_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 shared adder
// Computes op_a + rotl(op_b, rot); used for every addition of the rounds
// and of the chaining value update.
// ----------------------------------------------------------------------------
module md5_alu (
    input  md5_pkg::alu_req_t            req,
    output logic [md5_pkg::WORD_W-1:0]   sum
);

    logic [2*md5_pkg::WORD_W-1:0] dbl;
    logic [md5_pkg::WORD_W-1:0]   rotated;

    // Rotate left by shifting a doubled copy and keeping the upper half.
    always_comb
    begin
        dbl     = {req.op_b, req.op_b} << req.rot;
        rotated = dbl[2*md5_pkg::WORD_W-1:md5_pkg::WORD_W];
        sum     = req.op_a + rotated;
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 hash engine testbench
// Feeds message byte items into the engine through a short table of known
// messages and then through random messages of many lengths, with idle
// bursts on both channels. Each digest word item is checked field by field
// against the oldest expected one, from a local MD5 model or a table digest.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS     = 300;
    localparam int QUIET_TAIL_START = 250;
    localparam int LONG_HOLD        = 2500;
    localparam int WATCHDOG_LIMIT   = 10000;
    localparam int TAIL_CYCLES      = 300;
    localparam int NUM_ROWS         = 17;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LENGTH_POS = 6'd56;

    // Known digests, words A to D.
    localparam logic [0:3][31:0] DIGEST_EMPTY =
        {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
    localparam logic [0:3][31:0] DIGEST_ABC =
        {32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};
    localparam logic [0:3][31:0] NO_DIGEST = '0;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_item_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              byte_ok;
        logic              eom;
        logic              has_digest;
        logic [0:3][31:0]  digest;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_hash_engine_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Model state of the hash.
    logic [31:0] chain_cv [4];
    logic [7:0]  block_buf [64];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    digest_item_t digest_q [$];

    // Typed digest that travels with the current input item.
    logic             item_has_digest;
    logic [0:3][31:0] item_digest;

    stim_row_t plan [NUM_ROWS];

    int  error_count = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    bit  long_hold_req = 1'b0;

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic restart_hash();
        chain_cv[0] = INIT_A;
        chain_cv[1] = INIT_B;
        chain_cv[2] = INIT_C;
        chain_cv[3] = INIT_D;
        msg_bits = '0;
        fill_pos = '0;
    endtask

    // Run the 64 rounds over the full block buffer.
    task automatic mix_block();
        logic [31:0] w [16];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] t;
        int g;
        int grp;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
        end
        a = chain_cv[0];
        b = chain_cv[1];
        c = chain_cv[2];
        d = chain_cv[3];
        for (int rnd = 0; rnd < 64; rnd++)
        begin
            grp = rnd / 16;
            case (grp)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = rnd;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * rnd + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * rnd + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * rnd) % 16;
                end
            endcase
            t = a + f + w[g] + ROUND_K[rnd];
            a = d;
            d = c;
            c = b;
            b = b + rotl32(t, ROUND_SHIFT[grp * 4 + rnd % 4]);
        end
        chain_cv[0] = chain_cv[0] + a;
        chain_cv[1] = chain_cv[1] + b;
        chain_cv[2] = chain_cv[2] + c;
        chain_cv[3] = chain_cv[3] + d;
    endtask

    task automatic load_block_byte(input logic [7:0] v);
        block_buf[fill_pos] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0)
        begin
            mix_block();
        end
    endtask

    // Pad, append the bit length and queue the four digest words.
    task automatic finish_message(input logic use_typed, input logic [0:3][31:0] typed);
        logic [63:0]  len_bits;
        digest_item_t item;
        len_bits = msg_bits;
        load_block_byte(PAD_BYTE);
        while (fill_pos != LENGTH_POS)
        begin
            load_block_byte(8'h00);
        end
        for (int k = 0; k < 8; k++)
        begin
            load_block_byte(len_bits[8*k +: 8]);
        end
        for (int k = 0; k < 4; k++)
        begin
            item.word  = use_typed ? typed[k] : chain_cv[k];
            item.index = 2'(k);
            item.last  = (k == 3);
            digest_q.push_back(item);
        end
        restart_hash();
    endtask

    // Predict on every accepted input item and check every digest word item.
    always @(posedge clk)
    begin : scoreboard
        digest_item_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (in_ch.byte_valid)
            begin
                load_block_byte(in_ch.data_byte);
                msg_bits = msg_bits + 64'd8;
            end
            if (in_ch.end_of_message)
            begin
                finish_message(item_has_digest, item_digest);
            end
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_q.size() == 0)
            begin
                flag_error($sformatf("digest word item %h with nothing pending",
                                     out_ch.digest_word));
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_ch.digest_word !== want.word)
                begin
                    flag_error($sformatf("digest_word %h, wanted %h",
                                         out_ch.digest_word, want.word));
                end
                if (out_ch.word_index !== want.index)
                begin
                    flag_error($sformatf("word_index %0d, wanted %0d",
                                         out_ch.word_index, want.index));
                end
                if (out_ch.last_word !== want.last)
                begin
                    flag_error($sformatf("last_word %b, wanted %b",
                                         out_ch.last_word, want.last));
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Digest receiver: random idle bursts and one long hold-off.
    initial
    begin : receiver
        int n;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n - 1) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one item, with an occasional idle burst first, and wait for it.
    task automatic offer_item(input logic [7:0] data, input logic byte_ok, input logic eom,
                              input logic has_digest, input logic [0:3][31:0] digest);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.byte_valid     <= byte_ok;
        in_ch.end_of_message <= eom;
        item_has_digest      <= has_digest;
        item_digest          <= digest;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending until every pending digest word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : stimulus
        int  items_sent;
        int  msg_count;
        int  len;
        bit  eom_on_byte;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= 8'h00;
        in_ch.byte_valid     <= 1'b0;
        in_ch.end_of_message <= 1'b0;
        item_has_digest      <= 1'b0;
        item_digest          <= NO_DIGEST;
        rst_n                <= 1'b0;
        restart_hash();
        for (int i = 0; i < 64; i++)
        begin
            block_buf[i] = 8'h00;
        end

        // Known messages, extremes, ignored items and ends without a byte.
        plan = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
            '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
            '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},
            '{8'hA5, 1'b0, 1'b1, 1'b0, NO_DIGEST},
            '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
            '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
            '{8'h5A, 1'b0, 1'b0, 1'b0, NO_DIGEST},
            '{8'hC3, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
            '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
            '{8'h7E, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
            '{8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            offer_item(plan[i].data, plan[i].byte_ok, plan[i].eom,
                       plan[i].has_digest, plan[i].digest);
        end
        wait_drained();

        // Random messages, mostly short, some around the padding boundaries.
        items_sent = 0;
        msg_count  = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= QUIET_TAIL_START)
            begin
                idle_on = 1'b0;
            end
            if (msg_count == 2)
            begin
                long_hold_req = 1'b1;
            end
            if (msg_count == 6)
            begin
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 6);
                7:                   len = $urandom_range(54, 57);
                8:                   len = $urandom_range(62, 66);
                default:             len = $urandom_range(118, 121);
            endcase
            eom_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
            begin
                // Ignored items scattered through the message.
                if ($urandom_range(0, 9) == 0)
                begin
                    offer_item(rand_byte(), 1'b0, 1'b0, 1'b0, NO_DIGEST);
                    items_sent++;
                end
                offer_item(rand_byte(), 1'b1, eom_on_byte && (i == len - 1),
                           1'b0, NO_DIGEST);
                items_sent++;
            end
            if (!eom_on_byte)
            begin
                offer_item(rand_byte(), 1'b0, 1'b1, 1'b0, NO_DIGEST);
                items_sent++;
            end
            msg_count++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
